@@ design/alp_pkg.sv @@
// Package for the additive lagged-Fibonacci generator: history geometry,
// seeding constants and the sequencer state type.
// No dependencies.
`default_nettype none

package alp_pkg;

  // history ring geometry
  localparam int HIST_DEPTH = 31;
  localparam int LAG_SHORT  = 3;
  localparam int POS_W      = $clog2(HIST_DEPTH);
  localparam int WORD_W     = 32;

  // seeding: Park-Miller step and the point where warm-up starts
  localparam int LCG_MULT   = 16807;
  localparam int LCG_MOD    = 2147483647;
  localparam int LCG_W      = 31;
  localparam int MULT_W     = 15;
  localparam int PROD_W     = LCG_W + MULT_W;
  localparam int COPY_END   = 34;

  localparam int WARMUP_END_DEF = 344;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_NEXT_WB,
    ST_LCG_MUL,
    ST_LCG_RED,
    ST_WARM_RD,
    ST_WARM_WB
  } state_t;

endpackage

`default_nettype wire

@@ design/alp_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module alp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 31
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read, held while not enabled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ design/additive_lagged_prng.sv @@
// Additive lagged-Fibonacci generator, top level: sequencer, seeding datapath,
// history memories and output register. Depends on alp_pkg and alp_ram.
//
// Usage: the item channel (item_valid/item_stall) carries operation and
// seed_value. operation 0 asks for the next number; operation 1 reseeds.
// The result channel (result_valid/result_stall) carries random_value, one
// transaction for each next request and none for a reseed.
// A next request is accepted from idle; the history read-modify-write reads
// both lags in the accepting cycle, then adds, writes back and loads the output
// register in the write-back state, which waits while the result is stalled;
// a new request is accepted only after that write-back.
// A reseed writes the seed word in the accepting cycle, then steps each seeded
// word through the multiplier and fold states and each warm-up step through
// the read and write-back states on the history memories, with item_stall
// high in all of them but the accepting cycle.
// Reset (rst, synchronous) clears the sequencer and the per-word valid flags,
// so the history reads as all zeros until seeded.
// A stalled result holds in the output register; one further next request is
// accepted and waits at write-back until the register frees.
`default_nettype none

module additive_lagged_prng #(
  parameter int WARMUP_END = alp_pkg::WARMUP_END_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        item_valid,
  output logic             item_stall,
  input  wire logic        operation,
  input  wire logic signed [31:0] seed_value,
  output logic             result_valid,
  input  wire logic        result_stall,
  output logic      [30:0] random_value
);

  localparam int POS_W  = alp_pkg::POS_W;
  localparam int WORD_W = alp_pkg::WORD_W;
  localparam int LCG_W  = alp_pkg::LCG_W;
  localparam int PROD_W = alp_pkg::PROD_W;
  localparam int CNT_W  = $clog2(WARMUP_END + 1);
  localparam bit WARM_ON = (WARMUP_END > alp_pkg::COPY_END);

  alp_pkg::state_t state, state_next;

  logic [POS_W-1:0]  pos, pos_inc, short_pos, idx;
  logic [POS_W:0]    short_sum;
  logic [CNT_W-1:0]  warm_cnt, warm_cnt_inc;
  logic [LCG_W-1:0]  lcg_w, lcg_next_word, seed_reduced;
  logic [PROD_W-1:0] lcg_prod;
  logic [WORD_W-1:0] lcg_fold, seed_bits, seed_plus_mod;
  logic [alp_pkg::HIST_DEPTH-1:0] hist_valid;
  logic              valid_a, valid_b;
  logic [WORD_W-1:0] rd_data_a, rd_data_b, sum_word;
  logic              accept, out_free, rd_en, wr_en, load_out;
  logic              lcg_last, warm_last;
  logic [POS_W-1:0]  wr_addr;
  logic [WORD_W-1:0] wr_data;

  assign accept   = item_valid && !item_stall;
  assign out_free = !result_valid || !result_stall;

  // ring arithmetic: short lag sits 28 slots ahead of the oldest word
  always_comb begin
    short_sum = {1'b0, pos} + (POS_W+1)'(alp_pkg::HIST_DEPTH - alp_pkg::LAG_SHORT);
    if (short_sum >= (POS_W+1)'(alp_pkg::HIST_DEPTH)) begin
      short_sum = short_sum - (POS_W+1)'(alp_pkg::HIST_DEPTH);
    end
    short_pos = short_sum[POS_W-1:0];
    pos_inc   = (pos == POS_W'(alp_pkg::HIST_DEPTH - 1)) ? '0 : pos + POS_W'(1);
  end

  // feedback sum, unwritten words read as zero
  assign sum_word = (valid_a ? rd_data_a : '0) + (valid_b ? rd_data_b : '0);

  // reduce the signed seed into 0..LCG_MOD-1
  assign seed_bits     = seed_value;
  assign seed_plus_mod = seed_bits + WORD_W'(alp_pkg::LCG_MOD);
  always_comb begin
    priority if (seed_bits == 32'h7FFF_FFFF) begin
      seed_reduced = '0;
    end else if (seed_bits == 32'h8000_0000) begin
      seed_reduced = LCG_W'(alp_pkg::LCG_MOD - 1);
    end else if (seed_bits[31]) begin
      seed_reduced = seed_plus_mod[LCG_W-1:0];
    end else begin
      seed_reduced = seed_bits[LCG_W-1:0];
    end
  end

  // fold the product modulo 2^31-1: high part plus low part, one correction
  always_comb begin
    lcg_fold = WORD_W'(lcg_prod[LCG_W-1:0]) + WORD_W'(lcg_prod[PROD_W-1:LCG_W]);
    if (lcg_fold >= WORD_W'(alp_pkg::LCG_MOD)) begin
      lcg_next_word = LCG_W'(lcg_fold - WORD_W'(alp_pkg::LCG_MOD));
    end else begin
      lcg_next_word = lcg_fold[LCG_W-1:0];
    end
  end

  assign lcg_last     = (idx == POS_W'(alp_pkg::HIST_DEPTH - 1));
  assign warm_cnt_inc = warm_cnt + CNT_W'(1);
  assign warm_last    = (warm_cnt_inc == CNT_W'(WARMUP_END));

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      alp_pkg::ST_IDLE: begin
        if (item_valid) begin
          state_next = operation ? alp_pkg::ST_LCG_MUL : alp_pkg::ST_NEXT_WB;
        end
      end
      alp_pkg::ST_NEXT_WB: begin
        if (out_free) state_next = alp_pkg::ST_IDLE;
      end
      alp_pkg::ST_LCG_MUL: state_next = alp_pkg::ST_LCG_RED;
      alp_pkg::ST_LCG_RED: begin
        if (lcg_last) begin
          state_next = WARM_ON ? alp_pkg::ST_WARM_RD : alp_pkg::ST_IDLE;
        end else begin
          state_next = alp_pkg::ST_LCG_MUL;
        end
      end
      alp_pkg::ST_WARM_RD: state_next = alp_pkg::ST_WARM_WB;
      alp_pkg::ST_WARM_WB: begin
        state_next = warm_last ? alp_pkg::ST_IDLE : alp_pkg::ST_WARM_RD;
      end
      default: state_next = alp_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs: memory strobes and the handshake
  always_comb begin
    item_stall = 1'b1;
    rd_en      = 1'b0;
    wr_en      = 1'b0;
    load_out   = 1'b0;
    wr_addr    = pos;
    wr_data    = sum_word;
    unique case (state)
      alp_pkg::ST_IDLE: begin
        item_stall = 1'b0;
        if (item_valid) begin
          if (operation) begin
            wr_en   = 1'b1;
            wr_addr = '0;
            wr_data = seed_bits;
          end else begin
            rd_en = 1'b1;
          end
        end
      end
      alp_pkg::ST_NEXT_WB: begin
        if (out_free) begin
          wr_en    = 1'b1;
          load_out = 1'b1;
        end
      end
      alp_pkg::ST_LCG_MUL: begin
      end
      alp_pkg::ST_LCG_RED: begin
        wr_en   = 1'b1;
        wr_addr = idx;
        wr_data = WORD_W'(lcg_next_word);
      end
      alp_pkg::ST_WARM_RD: rd_en = 1'b1;
      alp_pkg::ST_WARM_WB: wr_en = 1'b1;
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= alp_pkg::ST_IDLE;
      pos          <= '0;
      idx          <= '0;
      warm_cnt     <= '0;
      hist_valid   <= '0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (wr_en) hist_valid[wr_addr] <= 1'b1;
      if (load_out) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
      if (load_out || state == alp_pkg::ST_WARM_WB) begin
        pos <= pos_inc;
      end else if (state == alp_pkg::ST_LCG_RED && lcg_last) begin
        pos <= POS_W'(alp_pkg::COPY_END - alp_pkg::HIST_DEPTH);
      end
      if (accept && operation) begin
        idx <= POS_W'(1);
      end else if (state == alp_pkg::ST_LCG_RED) begin
        idx <= idx + POS_W'(1);
      end
      if (state == alp_pkg::ST_LCG_RED && lcg_last) begin
        warm_cnt <= CNT_W'(alp_pkg::COPY_END);
      end else if (state == alp_pkg::ST_WARM_WB) begin
        warm_cnt <= warm_cnt_inc;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept && operation) begin
      lcg_w <= seed_reduced;
    end else if (state == alp_pkg::ST_LCG_RED) begin
      lcg_w <= lcg_next_word;
    end
    if (state == alp_pkg::ST_LCG_MUL) begin
      lcg_prod <= PROD_W'(lcg_w) * PROD_W'(alp_pkg::LCG_MULT);
    end
    if (rd_en) begin
      valid_a <= hist_valid[pos];
      valid_b <= hist_valid[short_pos];
    end
    if (load_out) begin
      random_value <= sum_word[WORD_W-1:1];
    end
  end

  // two copies of the history, one read port each for the two lags
  alp_ram #(
    .WIDTH(WORD_W),
    .DEPTH(alp_pkg::HIST_DEPTH)
  ) u_hist_long (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(pos),
    .rd_data(rd_data_a)
  );

  alp_ram #(
    .WIDTH(WORD_W),
    .DEPTH(alp_pkg::HIST_DEPTH)
  ) u_hist_short (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(short_pos),
    .rd_data(rd_data_b)
  );

  // a next request goes straight to write-back
  a_next_to_wb: assert property (@(posedge clk) disable iff (rst)
    (accept && !operation) |=> (state == alp_pkg::ST_NEXT_WB))
    else $error("next request did not reach write-back");

  // a reseed starts the fill at word one
  a_seed_start: assert property (@(posedge clk) disable iff (rst)
    (accept && operation) |=> (state == alp_pkg::ST_LCG_MUL && idx == POS_W'(1)))
    else $error("reseed did not start the fill at word one");

  // reads and writes of the history never share a cycle
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (rst)
    !(wr_en && rd_en))
    else $error("history read and write in the same cycle");

  // a stalled result blocks the write-back of the waiting request
  a_wb_waits: assert property (@(posedge clk) disable iff (rst)
    (state == alp_pkg::ST_NEXT_WB && result_valid && result_stall) |-> !wr_en)
    else $error("history written while the result is stalled");

  // end of the fill leaves the ring three words past the seed
  a_ring_after_fill: assert property (@(posedge clk) disable iff (rst)
    (state == alp_pkg::ST_LCG_RED && lcg_last) |=>
      (pos == POS_W'(alp_pkg::COPY_END - alp_pkg::HIST_DEPTH)))
    else $error("ring position wrong after seeding fill");

endmodule

`default_nettype wire
